### design/csb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csb_pkg: shared types and constants of the counting semaphore bank
// Field widths, operation and error codes, and the command and status
// records between the sequencer and the holder table.
// ----------------------------------------------------------------------------
package csb_pkg;

   localparam int NUM_SEMS_DEF    = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int HOLD_SLOTS_DEF  = 16;
   localparam int RESET_COUNT_DEF = 1;

   localparam int KIND_W   = 2;
   localparam int SEM_ID_W = 3;
   localparam int REQ_W    = 6;
   localparam int INIT_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int ERR_W    = 2;
   localparam int MATCH_W  = 2;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = COUNT_W'(255);

   localparam logic [KIND_W-1:0] KIND_ACQUIRE = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_RELEASE = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_INIT    = KIND_W'(2);

   localparam logic [ERR_W-1:0] ERR_OK         = ERR_W'(0);
   localparam logic [ERR_W-1:0] ERR_QUEUE_FULL = ERR_W'(1);
   localparam logic [ERR_W-1:0] ERR_HOLD_FULL  = ERR_W'(2);
   localparam logic [ERR_W-1:0] ERR_SATURATED  = ERR_W'(3);

   typedef enum logic [2:0] {
      HT_NONE,
      HT_SCAN,
      HT_GRANT,
      HT_WAKE,
      HT_DROP,
      HT_CLEAR_ROW,
      HT_CLEAR_ALL
   } ht_op_type;

   typedef struct packed {
      ht_op_type        op;
      logic [REQ_W-1:0] who;
      logic [REQ_W-1:0] ins_id;
   } ht_cmd_type;

   typedef struct packed {
      logic               done;
      logic               has_free;
      logic [MATCH_W-1:0] match_cnt;
   } ht_stat_type;

endpackage
`default_nettype wire

### design/csb_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csb_req_if: request channel
// Valid/ready channel carrying one semaphore operation.
// ----------------------------------------------------------------------------
interface csb_req_if import csb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SEM_ID_W-1:0] sem_id;
   logic [REQ_W-1:0]    requester;
   logic [INIT_W-1:0]   init_value;

   modport source (output valid, kind, sem_id, requester, init_value, input ready);
   modport sink   (input valid, kind, sem_id, requester, init_value, output ready);
endinterface
`default_nettype wire

### design/csb_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csb_rsp_if: response channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface csb_rsp_if import csb_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      granted;
   logic                      wake_valid;
   logic [REQ_W-1:0]          wake_id;
   logic                      holds;
   logic signed [COUNT_W-1:0] count_after;
   logic [ERR_W-1:0]          error_code;

   modport source (output valid, granted, wake_valid, wake_id, holds, count_after,
                   error_code, input ready);
   modport sink   (input valid, granted, wake_valid, wake_id, holds, count_after,
                   error_code, output ready);
endinterface
`default_nettype wire

### design/csb_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csb_csr_if: configuration write channel
// Valid/ready channel carrying the reset count register.
// ----------------------------------------------------------------------------
interface csb_csr_if import csb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [INIT_W-1:0] reset_count;

   modport source (output valid, reset_count, input ready);
   modport sink   (input valid, reset_count, output ready);
endinterface
`default_nettype wire

### design/csb_holder_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csb_holder_table: holder slots of every semaphore
// Holds holder ids in a memory with a valid flop per slot. A scan walks one
// slot per cycle through a single comparator and records the lowest free
// slot, the lowest slot of the requester and how often it appears, saturating at two.
// ----------------------------------------------------------------------------
module csb_holder_table import csb_pkg::*; #(
   parameter int NUM_SEMS   = NUM_SEMS_DEF,
   parameter int HOLD_SLOTS = HOLD_SLOTS_DEF,
   localparam int SEM_AW    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1,
   localparam int SAW       = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SEM_AW-1:0] sem,
   input  ht_cmd_type        cmd,
   output ht_stat_type       stat
);

   localparam logic [SAW-1:0] LAST_SLOT = SAW'(HOLD_SLOTS - 1);

   logic [REQ_W-1:0]      id_mem [NUM_SEMS][HOLD_SLOTS];
   logic [HOLD_SLOTS-1:0] valid_ff [NUM_SEMS];

   logic               scan_ff, cmp_ff, done_ff;
   logic [SAW-1:0]     slot_ff, rd_slot_ff;
   logic               rd_vld_ff;
   logic [REQ_W-1:0]   rd_id_ff;
   logic               free_vld_ff, match_vld_ff;
   logic [SAW-1:0]     free_slot_ff, match_slot_ff;
   logic [MATCH_W-1:0] match_cnt_ff;

   logic hit, ins_skip, do_insert, do_remove;
   logic [HOLD_SLOTS-1:0] valid_in;

   assign hit = rd_vld_ff && (rd_id_ff == cmd.who);

   // A waking waiter equal to the releaser that lands below its old entry, or that has
   // no old entry, is the entry the release removes again: leave the slot free.
   assign ins_skip  = (cmd.ins_id == cmd.who) &&
                      (!match_vld_ff || (free_slot_ff < match_slot_ff));
   assign do_insert = (cmd.op == HT_GRANT) || ((cmd.op == HT_WAKE) && !ins_skip);
   assign do_remove = match_vld_ff &&
                      (((cmd.op == HT_WAKE) && !ins_skip) || (cmd.op == HT_DROP));

   // next valid row of the addressed semaphore
   always_comb begin
      valid_in = valid_ff[sem];
      if (cmd.op == HT_CLEAR_ROW) begin
         valid_in = '0;
      end
      if (do_insert) begin
         valid_in[free_slot_ff] = 1'b1;
      end
      if (do_remove) begin
         valid_in[match_slot_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_insert) begin
         id_mem[sem][free_slot_ff] <= cmd.ins_id;
      end
      rd_id_ff <= id_mem[sem][slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.op == HT_CLEAR_ALL)) begin
         for (int s = 0; s < NUM_SEMS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if ((cmd.op == HT_CLEAR_ROW) || do_insert || do_remove) begin
         valid_ff[sem] <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_vld_ff  <= valid_ff[sem][slot_ff];
      rd_slot_ff <= slot_ff;
      if (reset) begin
         scan_ff      <= 1'b0;
         cmp_ff       <= 1'b0;
         done_ff      <= 1'b0;
         slot_ff      <= '0;
         free_vld_ff  <= 1'b0;
         match_vld_ff <= 1'b0;
         match_cnt_ff <= '0;
      end else begin
         cmp_ff <= scan_ff;
         if (cmd.op == HT_SCAN) begin
            scan_ff      <= 1'b1;
            slot_ff      <= '0;
            done_ff      <= 1'b0;
            free_vld_ff  <= 1'b0;
            match_vld_ff <= 1'b0;
            match_cnt_ff <= '0;
         end else begin
            if (scan_ff) begin
               if (slot_ff == LAST_SLOT) begin
                  scan_ff <= 1'b0;
               end else begin
                  slot_ff <= slot_ff + SAW'(1);
               end
            end
            if (cmp_ff) begin
               if (!rd_vld_ff && !free_vld_ff) begin
                  free_vld_ff  <= 1'b1;
                  free_slot_ff <= rd_slot_ff;
               end
               if (hit) begin
                  if (!match_vld_ff) begin
                     match_vld_ff  <= 1'b1;
                     match_slot_ff <= rd_slot_ff;
                  end
                  // saturate: only none, one or several matter
                  if (match_cnt_ff != MATCH_W'(2)) begin
                     match_cnt_ff <= match_cnt_ff + MATCH_W'(1);
                  end
               end
               if (rd_slot_ff == LAST_SLOT) begin
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign stat.done      = done_ff;
   assign stat.has_free  = free_vld_ff;
   assign stat.match_cnt = match_cnt_ff;

endmodule
`default_nettype wire

### design/counting_semaphore_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_bank: bank of counting semaphores with FIFO wait queues
// Sequencer, counts and wait rings; the holder slots live in csb_holder_table.
// ----------------------------------------------------------------------------
// One request is taken at a time. Init and requests to a semaphore beyond
// the bank go straight to the decision step after acceptance; acquire, release
// and the unused kind first wait for the holder slot scan, which compares one
// slot per cycle through a single comparator, followed by a compare and a
// decision step after the last slot is read. The next request is accepted
// from the cycle after the response is registered. The response sits in an
// output register, so the next request is accepted while it waits; a response
// still unread when the next request is decided holds that request in its
// last step. A configuration write reloads every count and empties all queues
// and holder tables in the cycle it is taken; the write port is always ready.
// ----------------------------------------------------------------------------
module counting_semaphore_bank import csb_pkg::*; #(
   parameter int NUM_SEMS    = NUM_SEMS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int HOLD_SLOTS  = HOLD_SLOTS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   csb_csr_if.sink   csr_ch,
   csb_req_if.sink   req_ch,
   csb_rsp_if.source rsp_ch
);

   localparam int SEM_AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int QAW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QMIN_I = -QUEUE_DEPTH;
   localparam logic signed [COUNT_W-1:0] Q_MIN     = COUNT_W'(QMIN_I);
   localparam logic [QAW-1:0]            LAST_PTR  = QAW'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {S_IDLE, S_WAIT, S_EXEC} state_type;

   state_type state_ff;

   // request held for the duration of the operation
   logic [KIND_W-1:0]   kind_ff;
   logic [SEM_ID_W-1:0] sem_ff;
   logic [REQ_W-1:0]    who_ff;
   logic [INIT_W-1:0]   initv_ff;
   logic                in_range_ff;

   logic signed [COUNT_W-1:0] count_ff [NUM_SEMS];
   logic [QAW-1:0]            head_ff  [NUM_SEMS];
   logic [QAW-1:0]            tail_ff  [NUM_SEMS];
   logic [REQ_W-1:0]          ring_mem [NUM_SEMS][QUEUE_DEPTH];
   logic [REQ_W-1:0]          ring_rd_ff;

   logic                      rsp_valid_ff;
   logic                      granted_ff, wake_valid_ff, holds_ff;
   logic [REQ_W-1:0]          wake_id_ff;
   logic signed [COUNT_W-1:0] count_after_ff;
   logic [ERR_W-1:0]          error_code_ff;

   logic [SEM_AW-1:0] sem_idx;
   logic              req_fire, csr_fire, rsp_fire, exec_fire;
   logic              in_range_now, needs_scan;

   logic signed [COUNT_W-1:0] cur_cnt, cnt_dec, cnt_inc, cnt_new;
   logic [QAW-1:0]            cur_head, cur_tail;
   logic                      cnt_we, push, pop, clr_ptr;
   ht_op_type                 ex_op;
   logic                      o_granted, o_wake, o_holds;
   logic [REQ_W-1:0]          o_wid;
   logic signed [COUNT_W-1:0] o_count;
   logic [ERR_W-1:0]          o_err;

   ht_cmd_type  ht_cmd;
   ht_stat_type ht_stat;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign csr_fire  = csr_ch.valid && csr_ch.ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ch.ready;
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign in_range_now = int'(req_ch.sem_id) < NUM_SEMS;
   assign needs_scan   = in_range_now && (req_ch.kind != KIND_INIT);

   assign sem_idx  = SEM_AW'(sem_ff);
   assign cur_cnt  = count_ff[sem_idx];
   assign cur_head = head_ff[sem_idx];
   assign cur_tail = tail_ff[sem_idx];
   assign cnt_dec  = cur_cnt - COUNT_W'(1);
   assign cnt_inc  = cur_cnt + COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= req_ch.kind;
         sem_ff      <= req_ch.sem_id;
         who_ff      <= req_ch.requester;
         initv_ff    <= req_ch.init_value;
         in_range_ff <= in_range_now;
      end
   end

   // decide the outcome from the count and the scan results
   always_comb begin
      o_granted = 1'b0;
      o_wake    = 1'b0;
      o_wid     = '0;
      o_holds   = (ht_stat.match_cnt != '0);
      o_count   = cur_cnt;
      o_err     = ERR_OK;
      cnt_we    = 1'b0;
      cnt_new   = cur_cnt;
      push      = 1'b0;
      pop       = 1'b0;
      clr_ptr   = 1'b0;
      ex_op     = HT_NONE;
      if (!in_range_ff) begin
         o_holds = 1'b0;
         o_count = '0;
      end else begin
         case (kind_ff)
            KIND_ACQUIRE: begin
               if (cnt_dec < Q_MIN) begin
                  o_err = ERR_QUEUE_FULL;
               end else if (cnt_dec[COUNT_W-1]) begin
                  push    = 1'b1;
                  cnt_we  = 1'b1;
                  cnt_new = cnt_dec;
               end else if (!ht_stat.has_free) begin
                  o_err = ERR_HOLD_FULL;
               end else begin
                  ex_op     = HT_GRANT;
                  o_granted = 1'b1;
                  o_holds   = 1'b1;
                  cnt_we    = 1'b1;
                  cnt_new   = cnt_dec;
               end
            end
            KIND_RELEASE: begin
               if (cur_cnt == COUNT_MAX) begin
                  o_err = ERR_SATURATED;
               end else if (cnt_inc[COUNT_W-1] || (cnt_inc == '0)) begin
                  if (!ht_stat.has_free) begin
                     o_err = ERR_HOLD_FULL;
                  end else begin
                     ex_op   = HT_WAKE;
                     pop     = 1'b1;
                     o_wake  = 1'b1;
                     o_wid   = ring_rd_ff;
                     cnt_we  = 1'b1;
                     cnt_new = cnt_inc;
                     // one entry of the releaser goes; the woken one may add one
                     o_holds = (ht_stat.match_cnt == MATCH_W'(2)) ||
                               ((ht_stat.match_cnt == MATCH_W'(1)) &&
                                (ring_rd_ff == who_ff));
                  end
               end else begin
                  ex_op   = HT_DROP;
                  cnt_we  = 1'b1;
                  cnt_new = cnt_inc;
                  o_holds = (ht_stat.match_cnt == MATCH_W'(2));
               end
            end
            KIND_INIT: begin
               ex_op   = HT_CLEAR_ROW;
               cnt_we  = 1'b1;
               cnt_new = COUNT_W'(initv_ff);
               clr_ptr = 1'b1;
               o_holds = 1'b0;
            end
            default: begin
            end
         endcase
         if (cnt_we) begin
            o_count = cnt_new;
         end
      end
   end

   always_comb begin
      ht_cmd.who    = who_ff;
      ht_cmd.ins_id = (ex_op == HT_WAKE) ? ring_rd_ff : who_ff;
      ht_cmd.op     = HT_NONE;
      if (csr_fire) begin
         ht_cmd.op = HT_CLEAR_ALL;
      end else if (req_fire && needs_scan) begin
         ht_cmd.op = HT_SCAN;
      end else if (exec_fire) begin
         ht_cmd.op = ex_op;
      end
   end

   csb_holder_table #(
      .NUM_SEMS   (NUM_SEMS),
      .HOLD_SLOTS (HOLD_SLOTS)
   ) u_holders (
      .clock (clock),
      .reset (reset),
      .sem   (sem_idx),
      .cmd   (ht_cmd),
      .stat  (ht_stat)
   );

   // wait ring: push at the tail, oldest waiter read from the head
   always_ff @(posedge clock) begin
      if (exec_fire && push) begin
         ring_mem[sem_idx][cur_tail] <= who_ff;
      end
      ring_rd_ff <= ring_mem[sem_idx][cur_head];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SEMS; s++) begin
            count_ff[s] <= COUNT_W'(RESET_COUNT_DEF);
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
         end
      end else if (csr_fire) begin
         for (int s = 0; s < NUM_SEMS; s++) begin
            count_ff[s] <= COUNT_W'(csr_ch.reset_count);
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
         end
      end else if (exec_fire) begin
         if (cnt_we) begin
            count_ff[sem_idx] <= cnt_new;
         end
         if (clr_ptr) begin
            head_ff[sem_idx] <= '0;
            tail_ff[sem_idx] <= '0;
         end
         if (push) begin
            tail_ff[sem_idx] <= (cur_tail == LAST_PTR) ? '0 : cur_tail + QAW'(1);
         end
         if (pop) begin
            head_ff[sem_idx] <= (cur_head == LAST_PTR) ? '0 : cur_head + QAW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_fire && !exec_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= needs_scan ? S_WAIT : S_EXEC;
               end
            end
            S_WAIT: begin
               if (ht_stat.done) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (exec_fire) begin
                  state_ff       <= S_IDLE;
                  rsp_valid_ff   <= 1'b1;
                  granted_ff     <= o_granted;
                  wake_valid_ff  <= o_wake;
                  wake_id_ff     <= o_wid;
                  holds_ff       <= o_holds;
                  count_after_ff <= o_count;
                  error_code_ff  <= o_err;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.granted     = granted_ff;
   assign rsp_ch.wake_valid  = wake_valid_ff;
   assign rsp_ch.wake_id     = wake_id_ff;
   assign rsp_ch.holds       = holds_ff;
   assign rsp_ch.count_after = count_after_ff;
   assign rsp_ch.error_code  = error_code_ff;

   a_refused_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (error_code_ff != ERR_OK) |-> !granted_ff && !wake_valid_ff)
      else $error("refused request reports a grant or a wakeup");

   a_grant_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && granted_ff |-> holds_ff)
      else $error("granted requester missing from holder table");

   a_wake_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && wake_valid_ff |-> (count_after_ff[COUNT_W-1] || (count_after_ff == '0)))
      else $error("wakeup with positive count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after accepting a request");

   a_table_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      (ht_cmd.op == HT_GRANT) || (ht_cmd.op == HT_WAKE) || (ht_cmd.op == HT_DROP)
      |-> exec_fire && ht_stat.done)
      else $error("holder table written without a finished scan");

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for counting_semaphore_bank
// A software copy of the bank predicts every response. A short directed pass
// exercises each operation, saturation, non-holder release, unknown kinds
// and the reset count register. Random traffic then runs in three phases,
// each with different idle ratios on the request and response channels.
// Some bursts fill the wait ring or the holder table of one semaphore.
// ----------------------------------------------------------------------------
module tb_top;
   import csb_pkg::*;

   localparam int SEMS  = NUM_SEMS_DEF;
   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int SLOTS = HOLD_SLOTS_DEF;

   localparam logic [KIND_W-1:0] KIND_UNUSED = KIND_W'(3);

   typedef struct packed {
      logic                      granted;
      logic                      wake_valid;
      logic [REQ_W-1:0]          wake_id;
      logic                      holds;
      logic signed [COUNT_W-1:0] count_after;
      logic [ERR_W-1:0]          error_code;
   } outcome_t;

   logic clock;
   logic reset;

   csb_csr_if csr_ch ();
   csb_req_if req_ch ();
   csb_rsp_if rsp_ch ();

   counting_semaphore_bank u_top (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // software copy of the bank
   logic signed [COUNT_W-1:0] sem_count_q [SEMS];
   int unsigned               ring_head   [SEMS];
   int unsigned               ring_tail   [SEMS];
   logic [REQ_W-1:0]          wait_ids    [SEMS][DEPTH];
   logic [REQ_W-1:0]          holder_ids  [SEMS][SLOTS];
   bit                        holder_on   [SEMS][SLOTS];

   outcome_t outcome_q [$];

   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int results_checked;
   int failures;
   int mismatches;
   int grants_seen;
   int wakes_seen;
   int err_seen [4];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------
   function automatic void clear_semaphore(int s, logic signed [COUNT_W-1:0] value);
      sem_count_q[s] = value;
      ring_head[s]   = 0;
      ring_tail[s]   = 0;
      for (int i = 0; i < SLOTS; i++) begin
         holder_on[s][i]  = 1'b0;
         holder_ids[s][i] = '0;
      end
   endfunction

   function automatic void load_bank(logic [INIT_W-1:0] value);
      for (int s = 0; s < SEMS; s++) clear_semaphore(s, COUNT_W'(value));
   endfunction

   function automatic int first_free(int s);
      for (int i = 0; i < SLOTS; i++) if (!holder_on[s][i]) return i;
      return -1;
   endfunction

   function automatic int holder_slot(int s, logic [REQ_W-1:0] who);
      for (int i = 0; i < SLOTS; i++)
         if (holder_on[s][i] && holder_ids[s][i] == who) return i;
      return -1;
   endfunction

   function automatic outcome_t semaphore_step(logic [KIND_W-1:0] kind,
                                               logic [SEM_ID_W-1:0] s,
                                               logic [REQ_W-1:0] who,
                                               logic [INIT_W-1:0] initv);
      outcome_t o;
      int slot;
      int nxt;
      o = '0;
      case (kind)
         KIND_ACQUIRE: begin
            nxt = int'(sem_count_q[s]) - 1;
            if (nxt < -DEPTH) begin
               o.error_code = ERR_QUEUE_FULL;
            end else if (nxt < 0) begin
               wait_ids[s][ring_tail[s]] = who;
               ring_tail[s]   = (ring_tail[s] + 1) % DEPTH;
               sem_count_q[s] = COUNT_W'(nxt);
            end else begin
               slot = first_free(s);
               if (slot < 0) begin
                  o.error_code = ERR_HOLD_FULL;
               end else begin
                  holder_ids[s][slot] = who;
                  holder_on[s][slot]  = 1'b1;
                  sem_count_q[s]      = COUNT_W'(nxt);
                  o.granted           = 1'b1;
               end
            end
         end
         KIND_RELEASE: begin
            nxt = int'(sem_count_q[s]) + 1;
            if (sem_count_q[s] >= COUNT_MAX) begin
               o.error_code = ERR_SATURATED;
            end else if (nxt <= 0) begin
               slot = first_free(s);
               if (slot < 0) begin
                  o.error_code = ERR_HOLD_FULL;
               end else begin
                  o.wake_valid        = 1'b1;
                  o.wake_id           = wait_ids[s][ring_head[s]];
                  ring_head[s]        = (ring_head[s] + 1) % DEPTH;
                  holder_ids[s][slot] = o.wake_id;
                  holder_on[s][slot]  = 1'b1;
                  sem_count_q[s]      = COUNT_W'(nxt);
               end
            end else begin
               sem_count_q[s] = COUNT_W'(nxt);
            end
            // drop the releaser's lowest entry, after the woken waiter went in
            if (o.error_code == ERR_OK) begin
               slot = holder_slot(s, who);
               if (slot >= 0) holder_on[s][slot] = 1'b0;
            end
         end
         KIND_INIT: clear_semaphore(s, COUNT_W'(initv));
         default: ;
      endcase
      o.holds       = (holder_slot(s, who) >= 0);
      o.count_after = sem_count_q[s];
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SEM_ID_W-1:0] s,
                               input logic [REQ_W-1:0] who, input logic [INIT_W-1:0] initv);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.sem_id     <= s;
      req_ch.requester  <= who;
      req_ch.init_value <= initv;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      outcome_q.push_back(semaphore_step(kind, s, who, initv));
      items_sent++;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reset_count(input logic [INIT_W-1:0] value);
      drain_responses();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.reset_count <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      load_bank(value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // response checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_t got;
      outcome_t want;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = '{rsp_ch.granted, rsp_ch.wake_valid, rsp_ch.wake_id, rsp_ch.holds,
                 rsp_ch.count_after, rsp_ch.error_code};
         if (outcome_q.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with no request outstanding: %p", $realtime, got);
         end else begin
            want = outcome_q.pop_front();
            results_checked++;
            if (got !== want) begin
               failures++;
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: mismatch granted %b/%b wake %b/%b id %0d/%0d holds %b/%b ",
                            "count %0d/%0d err %0d/%0d (expected/actual)"}, $realtime,
                           want.granted, got.granted, want.wake_valid, got.wake_valid,
                           want.wake_id, got.wake_id, want.holds, got.holds,
                           want.count_after, got.count_after,
                           want.error_code, got.error_code);
            end
            if (got.granted === 1'b1) grants_seen++;
            if (got.wake_valid === 1'b1) wakes_seen++;
            if (!$isunknown(got.error_code)) err_seen[got.error_code]++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [REQ_W-1:0] random_requester();
      return ($urandom_range(0, 3) == 0) ? REQ_W'($urandom) : REQ_W'($urandom_range(0, 11));
   endfunction

   // mostly release by a current holder so that counts and holders stay consistent
   task automatic release_request(input logic [SEM_ID_W-1:0] s);
      int               held [$];
      logic [REQ_W-1:0] who;
      for (int i = 0; i < SLOTS; i++) if (holder_on[s][i]) held.push_back(i);
      if (held.size() != 0 && $urandom_range(0, 9) < 7)
         who = holder_ids[s][held[$urandom_range(0, held.size() - 1)]];
      else
         who = random_requester();
      send_request(KIND_RELEASE, s, who, INIT_W'($urandom));
   endtask

   // one acquire past a full holder table: refused when the count allows a grant,
   // queued otherwise, and then a release cannot place the woken waiter
   task automatic fill_holders(input logic [SEM_ID_W-1:0] s);
      send_request(KIND_INIT, s, random_requester(), INIT_W'(SLOTS + $urandom_range(0, 1)));
      repeat (SLOTS + 1) send_request(KIND_ACQUIRE, s, REQ_W'($urandom), INIT_W'($urandom));
      send_request(KIND_RELEASE, s, REQ_W'($urandom), INIT_W'($urandom));
   endtask

   // one acquire past a full wait ring, then wake a few waiters
   task automatic fill_wait_ring(input logic [SEM_ID_W-1:0] s);
      int v;
      v = $urandom_range(0, 1);
      send_request(KIND_INIT, s, random_requester(), INIT_W'(v));
      repeat (v + DEPTH + 1) send_request(KIND_ACQUIRE, s, random_requester(), INIT_W'($urandom));
      repeat ($urandom_range(2, 6)) release_request(s);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed_ops();
      send_request(KIND_ACQUIRE, 3'd0, 6'd5,  8'd0);
      send_request(KIND_ACQUIRE, 3'd0, 6'd6,  8'd0);
      send_request(KIND_ACQUIRE, 3'd0, 6'd63, 8'd255);
      send_request(KIND_RELEASE, 3'd0, 6'd5,  8'd0);
      send_request(KIND_RELEASE, 3'd0, 6'd9,  8'd0);   // non-holder still wakes
      send_request(KIND_RELEASE, 3'd0, 6'd6,  8'd0);
      send_request(KIND_INIT,    3'd7, 6'd0,  8'd255);
      send_request(KIND_RELEASE, 3'd7, 6'd63, 8'd0);   // saturated
      send_request(KIND_UNUSED,  3'd7, 6'd0,  8'd255);
      send_request(KIND_INIT,    3'd1, 6'd0,  8'd0);
      send_request(KIND_ACQUIRE, 3'd1, 6'd0,  8'd0);
      send_request(KIND_INIT,    3'd1, 6'd0,  8'd170);  // flushes the queued waiter
      send_request(KIND_INIT,    3'd2, 6'd42, 8'd85);
      send_request(KIND_RELEASE, 3'd2, 6'd42, 8'd0);
      send_request(KIND_ACQUIRE, 3'd4, 6'd63, 8'd0);
      send_request(KIND_RELEASE, 3'd4, 6'd63, 8'd0);
      drain_responses();
   endtask

   task automatic test_reset_count();
      write_reset_count(8'd255);
      send_request(KIND_RELEASE, 3'd3, 6'd7, 8'd0);
      send_request(KIND_ACQUIRE, 3'd3, 6'd7, 8'd0);
      send_request(KIND_RELEASE, 3'd3, 6'd7, 8'd0);
      write_reset_count(8'd0);
      send_request(KIND_ACQUIRE, 3'd5, 6'd1, 8'd0);
      send_request(KIND_ACQUIRE, 3'd5, 6'd2, 8'd0);
      send_request(KIND_RELEASE, 3'd5, 6'd3, 8'd0);
      send_request(KIND_RELEASE, 3'd5, 6'd1, 8'd0);   // woken holder drops itself
      drain_responses();
   endtask

   task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct,
                                      input logic [INIT_W-1:0] rc);
      int                  stop_at;
      int                  next_pause;
      int                  pick;
      logic [SEM_ID_W-1:0] focus;
      logic [SEM_ID_W-1:0] s;
      logic [INIT_W-1:0]   v;
      write_reset_count(rc);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      fill_holders(SEM_ID_W'($urandom));
      fill_wait_ring(SEM_ID_W'($urandom));
      stop_at    = items_sent + n;
      next_pause = items_sent + 200;
      focus      = SEM_ID_W'($urandom);
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0) focus = SEM_ID_W'($urandom);
         s    = ($urandom_range(0, 4) == 0) ? SEM_ID_W'($urandom) : focus;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: v = INIT_W'($urandom_range(0, 3));
               4, 5:       v = INIT_W'($urandom_range(SLOTS - 1, SLOTS + 1));
               6:          v = 8'd255;
               default:    v = INIT_W'($urandom);
            endcase
            send_request(KIND_INIT, s, random_requester(), v);
         end else if (pick < 50) begin
            send_request(KIND_ACQUIRE, s, random_requester(), INIT_W'($urandom));
         end else if (pick < 88) begin
            release_request(s);
         end else if (pick < 93) begin
            send_request(KIND_UNUSED, s, REQ_W'($urandom), INIT_W'($urandom));
         end else if (pick < 98) begin
            send_request(KIND_W'($urandom), SEM_ID_W'($urandom), REQ_W'($urandom),
                         INIT_W'($urandom));
         end else if (pick == 98) begin
            fill_holders(s);
         end else begin
            fill_wait_ring(s);
         end
         // hold the sender until the bank has answered everything
         if (items_sent >= next_pause) begin
            drain_responses();
            next_pause += 200;
         end
      end
      drain_responses();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_ACQUIRE;
      req_ch.sem_id      = '0;
      req_ch.requester   = '0;
      req_ch.init_value  = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.reset_count = '0;
      send_idle_pct      = 20;
      recv_idle_pct      = 20;
      items_sent         = 0;
      results_checked    = 0;
      failures           = 0;
      mismatches         = 0;
      grants_seen        = 0;
      wakes_seen         = 0;
      for (int i = 0; i < 4; i++) err_seen[i] = 0;
      load_bank(INIT_W'(RESET_COUNT_DEF));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_reset_count();
      test_random_traffic(530, 35, 87, 8'd2);
      test_random_traffic(530, 87, 35, 8'd0);
      test_random_traffic(530, 0, 0, 8'd255);

      drain_responses();
      repeat (SLOTS + 8) @(posedge clock);
      if (outcome_q.size() != 0) failures++;

      $display("Sent %0d requests, checked %0d responses; %0d grants, %0d wakes.",
               items_sent, results_checked, grants_seen, wakes_seen);
      $display("Refusals seen: %0d queue full, %0d holder table full, %0d saturated.",
               err_seen[ERR_QUEUE_FULL], err_seen[ERR_HOLD_FULL], err_seen[ERR_SATURATED]);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### counting_semaphore_bank.f
design/csb_pkg.sv
design/csb_req_if.sv
design/csb_rsp_if.sv
design/csb_csr_if.sv
design/csb_holder_table.sv
design/counting_semaphore_bank.sv
test/tb_top.sv
